// ----- rtl/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types, command codes and phase tables for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam logic [2:0] CMD_START  = 3'd0;
	localparam logic [2:0] CMD_STOP   = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_GETACK = 3'd4;
	localparam logic [2:0] CMD_PUTACK = 3'd5;

	localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;
	localparam logic [4:0]  BIT_PHASES       = 5'd16;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] command;
		logic [7:0] write_data;
		logic       ack_to_send;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_seen;
	} report_t;

	// number of phases of a command
	function automatic logic [4:0] phase_last(input logic [2:0] cmd);
		logic [4:0] n;
		case (cmd)
			CMD_START: n = 5'd4;
			CMD_STOP:  n = 5'd3;
			CMD_WRITE: n = 5'd17;
			CMD_READ:  n = 5'd17;
			default:   n = 5'd3;
		endcase
		return n;
	endfunction

	// {scl, sda} of phase p
	function automatic logic [1:0] phase_levels(
		input logic [2:0] cmd,
		input logic [4:0] p,
		input logic       msb,
		input logic       ack_bit,
		input logic       sda_cur
	);
		logic scl;
		logic sda;
		case (cmd)
			CMD_START: begin
				scl = (p == 5'd1) || (p == 5'd2);
				sda = (p <= 5'd1);
			end
			CMD_STOP: begin
				scl = (p >= 5'd1);
				sda = (p == 5'd2);
			end
			CMD_WRITE: begin
				if (p < BIT_PHASES) begin
					scl = p[0];
					sda = msb;
				end else begin
					scl = 1'b0;
					sda = sda_cur;
				end
			end
			CMD_READ: begin
				scl = (p < BIT_PHASES) ? p[0] : 1'b0;
				sda = 1'b1;
			end
			CMD_GETACK: begin
				scl = (p == 5'd1);
				sda = 1'b1;
			end
			default: begin
				scl = (p == 5'd1);
				sda = ack_bit;
			end
		endcase
		return {scl, sda};
	endfunction

endpackage

// ----- rtl/i2cmbe_if.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_if
// Valid/ready channels for tick items and line report items.
// ----------------------------------------------------------------------------
interface i2cmbe_tick_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] command;
	logic [7:0] write_data;
	logic       ack_to_send;
	logic       sda_in;

	modport source (
		output valid, cmd_valid, command, write_data, ack_to_send, sda_in,
		input  ready
	);
	modport sink (
		input  valid, cmd_valid, command, write_data, ack_to_send, sda_in,
		output ready
	);
endinterface

interface i2cmbe_report_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_seen;

	modport source (
		output valid, scl_level, sda_release, busy_res, done_res, read_data, ack_seen,
		input  ready
	);
	modport sink (
		input  valid, scl_level, sda_release, busy_res, done_res, read_data, ack_seen,
		output ready
	);
endinterface

// ----- rtl/i2cmbe_core.sv -----
// ----------------------------------------------------------------------------
// i2cmbe_core
// Phase sequencer state; advances one tick per accepted item.
// ----------------------------------------------------------------------------
module i2cmbe_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  i2cmbe_pkg::tick_t   item,
	input  logic [15:0]         phase_ticks,
	output i2cmbe_pkg::report_t res
);

	logic [2:0]  cmd_q,   cmd_d;
	logic        busy_q,  busy_d;
	logic [4:0]  phase_q, phase_d;
	logic [15:0] hold_q,  hold_d;
	logic [7:0]  shift_q, shift_d;
	logic        scl_q,   scl_d;
	logic        sda_q,   sda_d;
	logic        ack_q,   ack_d;
	logic        abit_q,  abit_d;
	logic [7:0]  rhold_q, rhold_d;
	logic        done_d;
	logic [15:0] load;
	logic [15:0] hold_dec;
	logic [4:0]  phase_nxt;
	logic [1:0]  lv;

	always_comb begin
		cmd_d     = cmd_q;
		busy_d    = busy_q;
		phase_d   = phase_q;
		hold_d    = hold_q;
		shift_d   = shift_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		ack_d     = ack_q;
		abit_d    = abit_q;
		rhold_d   = rhold_q;
		done_d    = 1'b0;
		load      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
		hold_dec  = hold_q - {15'd0, (hold_q != 16'd0)};
		phase_nxt = phase_q + 5'd1;
		lv        = {scl_q, sda_q};
		if (busy_q) begin
			hold_d = hold_dec;
			if (hold_dec == 16'd0) begin
				if (cmd_q == i2cmbe_pkg::CMD_WRITE && phase_q < i2cmbe_pkg::BIT_PHASES
						&& phase_q[0]) begin
					shift_d = {shift_q[6:0], 1'b0};
				end else if (cmd_q == i2cmbe_pkg::CMD_READ
						&& phase_q < i2cmbe_pkg::BIT_PHASES && phase_q[0]) begin
					shift_d = {shift_q[6:0], item.sda_in};
				end else if (cmd_q == i2cmbe_pkg::CMD_GETACK && phase_q == 5'd1) begin
					ack_d = item.sda_in;
				end
				if (phase_nxt >= i2cmbe_pkg::phase_last(cmd_q)) begin
					busy_d  = 1'b0;
					done_d  = 1'b1;
					phase_d = 5'd0;
					if (cmd_q == i2cmbe_pkg::CMD_READ) begin
						rhold_d = shift_d;
					end
				end else begin
					phase_d = phase_nxt;
					lv      = i2cmbe_pkg::phase_levels(cmd_q, phase_nxt, shift_d[7],
						abit_q, sda_q);
					scl_d   = lv[1];
					sda_d   = lv[0];
					hold_d  = load;
				end
			end
		end else if (item.cmd_valid && item.command <= i2cmbe_pkg::CMD_PUTACK) begin
			cmd_d   = item.command;
			busy_d  = 1'b1;
			phase_d = 5'd0;
			if (item.command == i2cmbe_pkg::CMD_WRITE) begin
				shift_d = item.write_data;
			end else if (item.command == i2cmbe_pkg::CMD_READ) begin
				shift_d = 8'd0;
			end
			if (item.command == i2cmbe_pkg::CMD_PUTACK) begin
				abit_d = item.ack_to_send;
			end
			lv     = i2cmbe_pkg::phase_levels(item.command, 5'd0, shift_d[7], abit_d, sda_q);
			scl_d  = lv[1];
			sda_d  = lv[0];
			hold_d = load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cmbe_pkg::CMD_START;
			busy_q  <= 1'b0;
			phase_q <= 5'd0;
			hold_q  <= 16'd0;
			shift_q <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			abit_q  <= 1'b0;
			rhold_q <= 8'd0;
		end else if (step) begin
			cmd_q   <= cmd_d;
			busy_q  <= busy_d;
			phase_q <= phase_d;
			hold_q  <= hold_d;
			shift_q <= shift_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			abit_q  <= abit_d;
			rhold_q <= rhold_d;
		end
	end

	assign res = '{scl_level: scl_d, sda_release: sda_d, busy_res: busy_d,
		done_res: done_d, read_data: rhold_d, ack_seen: ack_d};

	a_hold_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> hold_q != 16'd0)
		else $error("busy with empty phase timer");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> phase_q < i2cmbe_pkg::phase_last(cmd_q))
		else $error("phase index past end of command");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> phase_q == 5'd0)
		else $error("idle with nonzero phase index");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && done_d |=> !busy_q)
		else $error("done tick left engine busy");

	a_fall_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(step))
		else $error("busy cleared without a tick");

endmodule

// ----- rtl/i2c_master_bit_engine_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master line sequencer: one tick item in, one line report item out.
// ----------------------------------------------------------------------------
//  channel   | kind             | payload
//  tick      | valid/ready sink | cmd_valid, command, write_data, ack_to_send, sda_in
//  report    | valid/ready src  | scl_level, sda_release, busy_res, done_res,
//            |                  | read_data, ack_seen
//  cfg       | write enable     | cfg_wdata = phase_ticks
//
//  One tick item per cycle; its report sits in the output register the next cycle.
//  The tick side stalls only while that register holds an item not yet taken.
//  Reset: lines released high, idle, phase_ticks 250, no report pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
	input  logic          clk,
	input  logic          arst_n,
	i2cmbe_tick_if.sink   tick,
	i2cmbe_report_if.source report,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);

	logic                pt_zero;
	logic [15:0]         pt_q;
	logic                step;
	logic                out_valid_q;
	i2cmbe_pkg::tick_t   item;
	i2cmbe_pkg::report_t res;
	i2cmbe_pkg::report_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= i2cmbe_pkg::PHASE_TICKS_RESET;
		end else if (cfg_we) begin
			pt_q <= cfg_wdata;
		end
	end

	assign pt_zero = (pt_q == 16'd0);

	assign tick.ready = !out_valid_q || report.ready;
	assign step       = tick.valid && tick.ready;

	assign item = '{cmd_valid: tick.cmd_valid, command: tick.command,
		write_data: tick.write_data, ack_to_send: tick.ack_to_send, sda_in: tick.sda_in};

	i2cmbe_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item),
		.phase_ticks (pt_zero ? 16'd1 : pt_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign report.valid       = out_valid_q;
	assign report.scl_level   = out_q.scl_level;
	assign report.sda_release = out_q.sda_release;
	assign report.busy_res    = out_q.busy_res;
	assign report.done_res    = out_q.done_res;
	assign report.read_data   = out_q.read_data;
	assign report.ack_seen    = out_q.ack_seen;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master bit engine. A fixed table of tick
// items (reset levels, spare codes, every command, commands landing while busy
// and on the done tick) runs first. Random command sequences follow over
// several phase_ticks settings, from zero up to 65535. Every report item is
// compared field by field with an in-bench model of the line sequencer.
// Random idling on both channels and one long output stall are included.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int PRINT_LIMIT = 30;

	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam logic [4:0] PHASES_PER_CMD [0:5] = '{5'd4, 5'd3, 5'd17, 5'd17, 5'd3, 5'd3};

	localparam i2cmbe_pkg::report_t REP_NONE    = '0;
	localparam i2cmbe_pkg::report_t REP_RESET   = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam i2cmbe_pkg::report_t REP_START0  = '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam i2cmbe_pkg::report_t REP_WR_LOW  = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam i2cmbe_pkg::report_t REP_WR_HIGH = '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

	typedef struct {
		bit                  wr;
		logic [15:0]         val;
		i2cmbe_pkg::tick_t   t;
		int                  idles;
		bit                  typed;
		i2cmbe_pkg::report_t rep;
	} plan_row_t;

	localparam int PLAN_ROWS = 21;
	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{1'b0, 16'd0, '{1'b0, i2cmbe_pkg::CMD_START,  8'h00, 1'b0, 1'b0},  0, 1'b1, REP_RESET},
		'{1'b0, 16'd0, '{1'b1, CMD_SPARE6,             8'hFF, 1'b1, 1'b1},  0, 1'b1, REP_RESET},
		'{1'b0, 16'd0, '{1'b1, CMD_SPARE7,             8'h00, 1'b0, 1'b0},  0, 1'b1, REP_RESET},
		// zero ticks behaves as one
		'{1'b1, 16'd0, '0,                                                  0, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_START,  8'h00, 1'b0, 1'b1},  4, 1'b1, REP_START0},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_WRITE,  8'h00, 1'b0, 1'b0}, 17, 1'b1, REP_WR_LOW},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_WRITE,  8'hFF, 1'b1, 1'b1}, 17, 1'b1, REP_WR_HIGH},
		// second command lands while busy, third on the done tick
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_WRITE,  8'h5A, 1'b0, 1'b0}, 15, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_START,  8'h00, 1'b0, 1'b1},  0, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_STOP,   8'h00, 1'b0, 1'b1},  0, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_READ,   8'h00, 1'b0, 1'b1}, 17, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_READ,   8'hFF, 1'b1, 1'b0}, 17, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_GETACK, 8'h00, 1'b0, 1'b1},  3, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_GETACK, 8'h00, 1'b0, 1'b0},  3, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_PUTACK, 8'h00, 1'b1, 1'b0},  3, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_PUTACK, 8'h00, 1'b0, 1'b1},  3, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_STOP,   8'h00, 1'b0, 1'b0},  3, 1'b0, REP_NONE},
		'{1'b1, 16'd2, '0,                                                  0, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_START,  8'h00, 1'b0, 1'b0},  8, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b1, i2cmbe_pkg::CMD_GETACK, 8'h00, 1'b0, 1'b1},  6, 1'b0, REP_NONE},
		'{1'b0, 16'd0, '{1'b0, i2cmbe_pkg::CMD_PUTACK, 8'hFF, 1'b1, 1'b1},  2, 1'b0, REP_NONE}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	i2cmbe_tick_if   tick_ch ();
	i2cmbe_report_if rep_ch ();

	i2c_master_bit_engine_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.report    (rep_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// line sequencer model state
	logic [15:0] m_ticks  = i2cmbe_pkg::PHASE_TICKS_RESET;
	logic [2:0]  m_cmd    = i2cmbe_pkg::CMD_START;
	logic        m_busy   = 1'b0;
	logic [4:0]  m_phase  = 5'd0;
	logic [15:0] m_hold   = 16'd0;
	logic [7:0]  m_shift  = 8'h00;
	logic        m_scl    = 1'b1;
	logic        m_sda    = 1'b1;
	logic        m_ack    = 1'b0;
	logic        m_ackbit = 1'b0;
	logic [7:0]  m_rdata  = 8'h00;

	i2cmbe_pkg::report_t due_reports [$];
	bit                  typed_on = 1'b0;
	i2cmbe_pkg::report_t typed_rep = REP_NONE;
	bit                  calm = 1'b0;

	int n_ticks   = 0;
	int n_reports = 0;
	int n_started = 0;
	int n_done    = 0;
	int n_cfg     = 0;
	int errors    = 0;

	always #5ns clk = ~clk;

	function automatic logic [15:0] hold_load();
		return (m_ticks == 16'd0) ? 16'd1 : m_ticks;
	endfunction

	function automatic void drive_phase(input logic [4:0] p);
		case (m_cmd)
			i2cmbe_pkg::CMD_START: begin
				m_scl = (p == 5'd1) || (p == 5'd2);
				m_sda = (p <= 5'd1);
			end
			i2cmbe_pkg::CMD_STOP: begin
				m_scl = (p != 5'd0);
				m_sda = (p == 5'd2);
			end
			i2cmbe_pkg::CMD_WRITE: begin
				if (p < i2cmbe_pkg::BIT_PHASES) begin
					m_scl = p[0];
					m_sda = m_shift[7];
				end else begin
					m_scl = 1'b0;
				end
			end
			i2cmbe_pkg::CMD_READ: begin
				m_scl = (p < i2cmbe_pkg::BIT_PHASES) && p[0];
				m_sda = 1'b1;
			end
			i2cmbe_pkg::CMD_GETACK: begin
				m_scl = (p == 5'd1);
				m_sda = 1'b1;
			end
			default: begin
				m_scl = (p == 5'd1);
				m_sda = m_ackbit;
			end
		endcase
	endfunction

	function automatic i2cmbe_pkg::report_t predict_report(input i2cmbe_pkg::tick_t t);
		logic done;
		done = 1'b0;
		if (m_busy) begin
			if (m_hold != 16'd0)
				m_hold = m_hold - 16'd1;
			if (m_hold == 16'd0) begin
				if (m_phase < i2cmbe_pkg::BIT_PHASES && m_phase[0]) begin
					if (m_cmd == i2cmbe_pkg::CMD_WRITE)
						m_shift = m_shift << 1;
					else if (m_cmd == i2cmbe_pkg::CMD_READ)
						m_shift = {m_shift[6:0], t.sda_in};
				end
				if (m_cmd == i2cmbe_pkg::CMD_GETACK && m_phase == 5'd1)
					m_ack = t.sda_in;
				m_phase = m_phase + 5'd1;
				if (m_phase >= PHASES_PER_CMD[m_cmd]) begin
					m_busy  = 1'b0;
					done    = 1'b1;
					m_phase = 5'd0;
					if (m_cmd == i2cmbe_pkg::CMD_READ)
						m_rdata = m_shift;
				end else begin
					drive_phase(m_phase);
					m_hold = hold_load();
				end
			end
		end else if (t.cmd_valid && t.command <= i2cmbe_pkg::CMD_PUTACK) begin
			m_cmd   = t.command;
			m_busy  = 1'b1;
			m_phase = 5'd0;
			if (t.command == i2cmbe_pkg::CMD_WRITE)
				m_shift = t.write_data;
			else if (t.command == i2cmbe_pkg::CMD_READ)
				m_shift = 8'h00;
			if (t.command == i2cmbe_pkg::CMD_PUTACK)
				m_ackbit = t.ack_to_send;
			drive_phase(5'd0);
			m_hold = hold_load();
		end
		return {m_scl, m_sda, m_busy, done, m_rdata, m_ack};
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("t=%0t report %0d %s: expected %0h, got %0h",
					$time, n_reports, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		i2cmbe_pkg::tick_t   seen;
		i2cmbe_pkg::report_t want;
		i2cmbe_pkg::report_t got;
		logic                was_busy;
		if (arst_n) begin
			if (cfg_we)
				m_ticks = cfg_wdata;
			if (tick_ch.valid && tick_ch.ready) begin
				seen = {tick_ch.cmd_valid, tick_ch.command, tick_ch.write_data,
					tick_ch.ack_to_send, tick_ch.sda_in};
				was_busy = m_busy;
				want = predict_report(seen);
				if (!was_busy && m_busy)
					n_started++;
				if (want.done_res)
					n_done++;
				if (typed_on)
					want = typed_rep;
				due_reports.push_back(want);
				n_ticks++;
			end
			if (rep_ch.valid && rep_ch.ready) begin
				got = {rep_ch.scl_level, rep_ch.sda_release, rep_ch.busy_res,
					rep_ch.done_res, rep_ch.read_data, rep_ch.ack_seen};
				n_reports++;
				if (due_reports.size() == 0) begin
					errors++;
					if (errors <= PRINT_LIMIT)
						$display("t=%0t report %0d: expected none, got %h",
							$time, n_reports, got);
				end else begin
					want = due_reports.pop_front();
					check_field("scl_level", want.scl_level, got.scl_level);
					check_field("sda_release", want.sda_release, got.sda_release);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("read_data", want.read_data, got.read_data);
					check_field("ack_seen", want.ack_seen, got.ack_seen);
				end
			end
		end
	end

	// report side: random stalls, one long hold while ticks keep coming
	initial begin
		int  hold_left;
		bit  hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		rep_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rep_ch.ready = 1'b0;
				hold_left--;
			end else if (!hold_used && n_ticks >= 700) begin
				hold_used = 1'b1;
				hold_left = 59;
				rep_ch.ready = 1'b0;
			end else begin
				rep_ch.ready = calm || ($urandom_range(99) >= 15);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d reports outstanding",
			CYCLE_LIMIT, due_reports.size());
		$display("== FAIL ==");
		$finish;
	end

	// entered and left at a falling edge
	task automatic offer(input i2cmbe_pkg::tick_t t);
		if (!calm && $urandom_range(99) < 15) begin
			tick_ch.valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		{tick_ch.cmd_valid, tick_ch.command, tick_ch.write_data,
			tick_ch.ack_to_send, tick_ch.sda_in} = t;
		tick_ch.valid = 1'b1;
		do @(posedge clk); while (!tick_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		tick_ch.valid = 1'b0;
		while (due_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (due_reports.size() != 0) begin
			errors++;
			$display("t=%0t %0d reports never arrived", $time, due_reports.size());
			due_reports.delete();
		end
	endtask

	task automatic set_phase_ticks(input logic [15:0] v);
		drain();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		n_cfg++;
	endtask

	function automatic i2cmbe_pkg::tick_t pick_tick(output bit counts, output bit starts);
		i2cmbe_pkg::tick_t t;
		int unsigned       r;
		bit                ending;
		t.cmd_valid   = 1'b0;
		t.command     = 3'($urandom_range(5));
		t.write_data  = 8'($urandom);
		t.ack_to_send = 1'($urandom);
		t.sda_in      = 1'($urandom);
		counts = 1'b1;
		starts = 1'b0;
		r = $urandom_range(99);
		if (!m_busy) begin
			if (r < 60) begin
				t.cmd_valid = 1'b1;
				starts = 1'b1;
			end else if (r < 70) begin
				t.cmd_valid = 1'b1;
				t.command = r[0] ? CMD_SPARE6 : CMD_SPARE7;
				counts = 1'b0;
			end
		end else begin
			ending = (m_hold == 16'd1) && (m_phase + 5'd1 >= PHASES_PER_CMD[m_cmd]);
			if (r < (ending ? 40 : 8)) begin
				t.cmd_valid = 1'b1;
				counts = 1'b0;
			end
		end
		return t;
	endfunction

	// to_idle: keep ticking until the running command has finished
	task automatic run_phase(input logic [15:0] pt, input int n, input bit quiet,
			input bit to_idle);
		i2cmbe_pkg::tick_t t;
		bit                counts;
		bit                starts;
		bit                began;
		bit                paused;
		int                sent;
		set_phase_ticks(pt);
		calm = quiet;
		sent = 0;
		began = 1'b0;
		paused = 1'b0;
		while (sent < n || !began || (to_idle && m_busy)) begin
			t = pick_tick(counts, starts);
			offer(t);
			if (counts)
				sent++;
			if (starts)
				began = 1'b1;
			if (!paused && sent >= n / 2) begin
				paused = 1'b1;
				drain();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		i2cmbe_pkg::tick_t idle;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		tick_ch.valid = 1'b0;
		tick_ch.cmd_valid = 1'b0;
		tick_ch.command = i2cmbe_pkg::CMD_START;
		tick_ch.write_data = 8'h00;
		tick_ch.ack_to_send = 1'b0;
		tick_ch.sda_in = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].wr) begin
				set_phase_ticks(plan[i].val);
			end else begin
				typed_on = plan[i].typed;
				typed_rep = plan[i].rep;
				offer(plan[i].t);
				typed_on = 1'b0;
				idle = plan[i].t;
				idle.cmd_valid = 1'b0;
				repeat (plan[i].idles) offer(idle);
			end
		end

		run_phase(16'd1, 420, 1'b0, 1'b1);
		run_phase(16'd2, 360, 1'b0, 1'b1);
		run_phase(16'd0, 240, 1'b1, 1'b1);
		run_phase(16'd3, 260, 1'b0, 1'b1);
		run_phase(16'd7, 180, 1'b0, 1'b1);
		// longest phase: only the first ticks of one command
		run_phase(16'hFFFF, 30, 1'b0, 1'b0);

		drain();
		repeat (4) @(posedge clk);
		$display("covered %0d tick items and %0d reports; %0d commands run, %0d done pulses",
			n_ticks, n_reports, n_started, n_done);
		$display("phase_ticks set %0d times, from 0 to 65535; %0d mismatches",
			n_cfg, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_if.sv
rtl/i2cmbe_core.sv
rtl/i2c_master_bit_engine_unit.sv
dv/tb_top.sv
